// ===== sv/slr_pkg.sv =====
// Package for the shallow line rasterizer: screen geometry, field widths,
// opcodes, status codes and the structs passed between the pipeline stages.
// No dependencies.
package slr_pkg;

    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 256;
    localparam int COORD_BITS    = 12;

    localparam int ADDR_BITS  = 17;
    localparam int COLOR_BITS = 8;
    localparam int DEC_BITS   = COORD_BITS + 4;   // decision value, signed
    localparam int FLAT_BITS  = COORD_BITS + 2;   // 2|dy|, unsigned
    localparam int STEP_BITS  = COORD_BITS + 3;   // 2(|dy| - dx), signed

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [1:0] ST_PIXEL = 2'd0;
    localparam logic [1:0] ST_STEEP = 2'd1;
    localparam logic [1:0] ST_IDLE  = 2'd2;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_color;

    // Pixel as produced by the step stage, before window check.
    typedef struct packed {
        logic [1:0]                   status;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        t_color                       color;
        logic                         last;
    } t_pixel;

endpackage

// ===== sv/slr_if.sv =====
// Request and result channel interfaces of the shallow line rasterizer.
// Depends on slr_pkg.
interface slr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [slr_pkg::COORD_BITS-1:0] first_x;
    logic signed [slr_pkg::COORD_BITS-1:0] first_y;
    logic signed [slr_pkg::COORD_BITS-1:0] second_x;
    logic signed [slr_pkg::COORD_BITS-1:0] second_y;
    logic [slr_pkg::COLOR_BITS-1:0]        red;
    logic [slr_pkg::COLOR_BITS-1:0]        green;
    logic [slr_pkg::COLOR_BITS-1:0]        blue;

    modport source (output valid, opcode, first_x, first_y, second_x, second_y,
                    red, green, blue, input ready);
    modport sink   (input valid, opcode, first_x, first_y, second_x, second_y,
                    red, green, blue, output ready);
endinterface

interface slr_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic signed [slr_pkg::COORD_BITS-1:0] pixel_x;
    logic signed [slr_pkg::COORD_BITS-1:0] pixel_y;
    logic                                 in_window;
    logic [slr_pkg::ADDR_BITS-1:0]         pixel_address;
    logic [slr_pkg::COLOR_BITS-1:0]        out_red;
    logic [slr_pkg::COLOR_BITS-1:0]        out_green;
    logic [slr_pkg::COLOR_BITS-1:0]        out_blue;
    logic                                 last;

    modport source (output valid, status, pixel_x, pixel_y, in_window, pixel_address,
                    out_red, out_green, out_blue, last, input ready);
    modport sink   (input valid, status, pixel_x, pixel_y, in_window, pixel_address,
                    out_red, out_green, out_blue, last, output ready);
endinterface

// ===== sv/shallow_line_rasterizer.sv =====
// Shallow line rasterizer top level: step stage followed by address stage.
// Depends on slr_pkg, slr_if, slr_step and slr_addr.
//
//   channel  dir  payload
//   i_req    in   opcode, first_x/y, second_x/y, red, green, blue
//   o_res    out  status, pixel_x/y, in_window, pixel_address, colors, last
//
// One request per clock when not stalled; each is registered by both stages.
// The two stages share one enable: a held result stalls the whole pipeline,
// and i_req.ready is low only while o_res.valid is high and o_res.ready low.
// Synchronous active-low reset drops the active line and empties both stages.
module shallow_line_rasterizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slr_req_if.sink   i_req,
    slr_res_if.source o_res
);
    import slr_pkg::*;

    logic   en;
    logic   pix_valid;
    t_pixel pix;

    assign en = !o_res.valid || o_res.ready;

    slr_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_req       (i_req),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    slr_addr u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_pix_valid (pix_valid),
        .i_pix       (pix),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status != ST_PIXEL |->
            !o_res.in_window && !o_res.last && o_res.pixel_address == '0)
        else $error("status result carries pixel data");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.in_window |-> o_res.pixel_address == '0)
        else $error("address set outside window");
`endif

endmodule

// ===== sv/slr_step.sv =====
// Step stage: line setup and Bresenham stepping, holds the line state and
// registers the next pixel. Depends on slr_pkg and slr_req_if.
module slr_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    slr_req_if.sink         i_req,
    output logic            o_pix_valid,
    output slr_pkg::t_pixel o_pix
);
    import slr_pkg::*;

    localparam int XB = COORD_BITS + 1;

    logic                         r_active, n_active;
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_end, n_end;
    logic signed [DEC_BITS-1:0]   r_dec, n_dec;
    logic [FLAT_BITS-1:0]         r_flat, n_flat;
    logic signed [STEP_BITS-1:0]  r_step, n_step;
    logic                         r_down, n_down;
    t_color                       r_color, n_color;
    t_pixel                       r_pix, n_pix;
    logic                         r_pix_valid;

    logic                         accept;
    logic signed [XB-1:0]         ax, ay, bx, by, x0, y0, x1, y1, dx, dy;
    logic [XB-1:0]                ady;
    logic                         swap;

    assign i_req.ready = i_en;
    assign accept      = i_req.valid && i_en;

    always_comb begin
        ax   = XB'(i_req.first_x);
        ay   = XB'(i_req.first_y);
        bx   = XB'(i_req.second_x);
        by   = XB'(i_req.second_y);
        swap = bx < ax;
        x0   = swap ? bx : ax;
        y0   = swap ? by : ay;
        x1   = swap ? ax : bx;
        y1   = swap ? ay : by;
        dx   = x1 - x0;
        dy   = y1 - y0;
        ady  = dy[XB-1] ? XB'(-dy) : XB'(dy);

        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_end    = r_end;
        n_dec    = r_dec;
        n_flat   = r_flat;
        n_step   = r_step;
        n_down   = r_down;
        n_color  = r_color;
        n_pix    = '0;

        if (i_req.opcode == OP_START) begin
            if (ady > $unsigned(dx)) begin
                n_active     = 1'b0;
                n_pix.status = ST_STEEP;
            end else begin
                n_color  = '{red: i_req.red, green: i_req.green, blue: i_req.blue};
                n_cur_x  = COORD_BITS'(x0);
                n_cur_y  = COORD_BITS'(y0);
                n_end    = COORD_BITS'(x1);
                n_down   = dy[XB-1];
                n_flat   = FLAT_BITS'({ady, 1'b0});
                n_step   = $signed(STEP_BITS'({ady, 1'b0})) - $signed(STEP_BITS'({dx, 1'b0}));
                n_dec    = $signed(DEC_BITS'({ady, 1'b0})) - DEC_BITS'(dx);
                n_active = dx != '0;
                n_pix    = '{status: ST_PIXEL, x: n_cur_x, y: n_cur_y,
                             color: n_color, last: dx == '0};
            end
        end else if (!r_active) begin
            n_pix.status = ST_IDLE;
        end else begin
            n_cur_x = r_cur_x + COORD_BITS'(1);
            if (r_dec > 0) begin
                n_cur_y = r_down ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
                n_dec   = r_dec + DEC_BITS'(r_step);
            end else begin
                n_dec   = r_dec + $signed(DEC_BITS'(r_flat));
            end
            n_active = !(n_cur_x >= r_end);
            n_pix    = '{status: ST_PIXEL, x: n_cur_x, y: n_cur_y,
                         color: r_color, last: n_cur_x >= r_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pix_valid <= 1'b0;
        end else if (i_en) begin
            r_pix_valid <= accept;
            if (accept) begin
                r_active <= n_active;
            end
        end
        if (accept) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_end   <= n_end;
            r_dec   <= n_dec;
            r_flat  <= n_flat;
            r_step  <= n_step;
            r_down  <= n_down;
            r_color <= n_color;
            r_pix   <= n_pix;
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

endmodule

// ===== sv/slr_addr.sv =====
// Address stage: window check and framebuffer address, drives the result
// register. Depends on slr_pkg and slr_res_if.
module slr_addr (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_pix_valid,
    input  slr_pkg::t_pixel i_pix,
    slr_res_if.source       o_res
);
    import slr_pkg::*;

    localparam int UB = COORD_BITS + 1;

    logic                 r_valid;
    t_pixel               r_pix;
    logic                 r_in_window, n_in_window;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [UB-1:0]        ux, uy;

    always_comb begin
        // coordinates as unsigned once the sign bit is known clear
        ux = {1'b0, i_pix.x};
        uy = {1'b0, i_pix.y};
        n_in_window = i_pix.status == ST_PIXEL
                   && !i_pix.x[COORD_BITS-1] && !i_pix.y[COORD_BITS-1]
                   && ux < UB'(SCREEN_WIDTH) && uy < UB'(SCREEN_HEIGHT);
        n_addr = n_in_window ? ADDR_BITS'(uy * SCREEN_WIDTH + ux) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_pix_valid;
        end
        if (i_en && i_pix_valid) begin
            r_pix       <= i_pix;
            r_in_window <= n_in_window;
            r_addr      <= n_addr;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.status        = r_pix.status;
    assign o_res.pixel_x       = r_pix.x;
    assign o_res.pixel_y       = r_pix.y;
    assign o_res.in_window     = r_in_window;
    assign o_res.pixel_address = r_addr;
    assign o_res.out_red       = r_pix.color.red;
    assign o_res.out_green     = r_pix.color.green;
    assign o_res.out_blue      = r_pix.color.blue;
    assign o_res.last          = r_pix.last;

endmodule
